// ===== sv/upd_pkg.sv =====
package upd_pkg;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_DIG1  = 2'd1,
    PH_DIG2  = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_INVALID    = 2'd2;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic       first_digit_bad;
    logic [1:0] pending_error;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    phase: PH_TEXT, high_nibble: 4'd0, first_digit_bad: 1'b0, pending_error: ST_OK
  };

  typedef struct packed {
    logic       present;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] status;
  } dec_result_t;

  // Low four bits hold the digit value, bit 4 flags a non-hex byte.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

// ===== sv/upd_step.sv =====
module upd_step
  import upd_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  char_in,
  input  logic        end_of_string,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic [4:0] hv;
  logic       bad;

  assign hv  = hex_value(char_in);
  assign bad = hv[4];

  always_comb begin
    nxt = cur;
    res = '0;
    case (cur.phase)
      PH_TEXT: begin
        if (char_in == PERCENT_CHAR) begin
          if (end_of_string) begin
            res = '{present: 1'b1, byte_out: 8'd0, byte_valid: 1'b0,
                    string_done: 1'b1, status: ST_INCOMPLETE};
          end else begin
            nxt.phase = PH_DIG1;
          end
        end else begin
          res = '{present: 1'b1, byte_out: char_in, byte_valid: 1'b1,
                  string_done: end_of_string, status: ST_OK};
        end
      end
      PH_DIG1: begin
        if (end_of_string) begin
          res = '{present: 1'b1, byte_out: 8'd0, byte_valid: 1'b0,
                  string_done: 1'b1, status: ST_INCOMPLETE};
        end else begin
          nxt.high_nibble     = hv[3:0];
          nxt.first_digit_bad = bad;
          nxt.phase           = PH_DIG2;
        end
      end
      PH_DIG2: begin
        if (bad || cur.first_digit_bad) begin
          if (end_of_string) begin
            res = '{present: 1'b1, byte_out: 8'd0, byte_valid: 1'b0,
                    string_done: 1'b1, status: ST_INVALID};
          end else begin
            nxt.phase         = PH_DRAIN;
            nxt.pending_error = ST_INVALID;
          end
        end else begin
          res = '{present: 1'b1, byte_out: {cur.high_nibble, hv[3:0]}, byte_valid: 1'b1,
                  string_done: end_of_string, status: ST_OK};
          nxt.phase           = PH_TEXT;
          nxt.high_nibble     = 4'd0;
          nxt.first_digit_bad = 1'b0;
        end
      end
      default: begin
        if (end_of_string) begin
          res = '{present: 1'b1, byte_out: 8'd0, byte_valid: 1'b0,
                  string_done: 1'b1, status: cur.pending_error};
        end
      end
    endcase
    // every string starts from a clean state
    if (end_of_string) begin
      nxt = DEC_STATE_RESET;
    end
  end

endmodule

// ===== sv/url_percent_decoder_top.sv =====
// Words pass the input register, then the result register; one word per cycle unless
// stalled. A '%', first hex digit or drained byte yields a result only at string end.
// in_stall rises only when a result is waiting in the output register and is itself stalled.
// Reset (rst, synchronous, active high) empties both registers and returns the
// decoder to the plain-text phase with no pending error.
module url_percent_decoder_top
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       byte_valid,
  output logic       string_done,
  output logic [1:0] status
);

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_eos;
  dec_state_t  st;
  dec_state_t  st_next;
  dec_result_t res;
  logic        out_free;
  logic        s1_go;

  upd_step u_step (
    .cur           (st),
    .char_in       (s1_char),
    .end_of_string (s1_eos),
    .nxt           (st_next),
    .res           (res)
  );

  assign out_free = !out_valid || !out_stall;
  // a word that yields no result can always leave the input register
  assign s1_go    = s1_valid && (!res.present || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_char <= char_in;
      s1_eos  <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DEC_STATE_RESET;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && res.present;
    end
    if (out_free && s1_go && res.present) begin
      byte_out    <= res.byte_out;
      byte_valid  <= res.byte_valid;
      string_done <= res.string_done;
      status      <= res.status;
    end
  end

endmodule
